[rtl/core/plni_pkg.sv]
`timescale 1ns / 1ps
package plni_pkg;

    localparam int MAX_EXTENT = 64;
    localparam int EXT_W      = 7;
    localparam int CRD_W      = 6;
    localparam int IDX_W      = 24;
    localparam int PAIR_W     = 13;
    localparam int RECIP_W    = IDX_W + 1;
    localparam int N_STAGES   = 11;

    localparam logic [2:0] REG_EXTENT_X = 3'd0;
    localparam logic [2:0] REG_EXTENT_Y = 3'd1;
    localparam logic [2:0] REG_EXTENT_Z = 3'd2;
    localparam logic [2:0] REG_EXTENT_T = 3'd3;

    localparam logic [EXT_W-1:0] EXT_RESET = 7'd8;

    localparam logic [1:0] DIR_X = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_Z = 2'd2;
    localparam logic [1:0] DIR_T = 2'd3;

    typedef struct packed {
        logic [EXT_W-1:0] x;
        logic [EXT_W-1:0] y;
        logic [EXT_W-1:0] z;
        logic [EXT_W-1:0] t;
    } ext_t;

    typedef struct packed {
        logic [IDX_W-1:0]  site;
        logic [1:0]        dir;
        logic              fwd;
        logic [PAIR_W-1:0] p_xy;
        logic [PAIR_W-1:0] p_zt;
    } item_t;

    typedef struct packed {
        logic             bad;
        logic [1:0]       dir;
        logic             fwd;
        logic [IDX_W-1:0] rest;
        logic [IDX_W-1:0] q;
        logic [CRD_W-1:0] cx;
        logic [CRD_W-1:0] cy;
        logic [CRD_W-1:0] cz;
        logic [CRD_W-1:0] ct;
        logic [IDX_W-1:0] acc;
    } stage_t;

    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] v;
        v = raw;
        if (raw == '0)
        begin
            v = EXT_W'(1);
        end
        else if (raw > EXT_W'(MAX_EXTENT))
        begin
            v = EXT_W'(MAX_EXTENT);
        end
        return v;
    endfunction

    // estimate of rest / e from reciprocal; low by at most one
    function automatic logic [IDX_W-1:0] quot_est(input logic [IDX_W-1:0] rest,
                                                  input logic [RECIP_W-1:0] recip);
        logic [IDX_W+RECIP_W-1:0] prod;
        prod = (IDX_W+RECIP_W)'(rest) * (IDX_W+RECIP_W)'(recip);
        return prod[2*IDX_W-1:IDX_W];
    endfunction

    function automatic logic [CRD_W-1:0] step_coord(input logic [CRD_W-1:0] c,
                                                    input logic [EXT_W-1:0] e,
                                                    input logic fwd);
        logic [EXT_W-1:0] up;
        logic [EXT_W-1:0] res;
        up = EXT_W'(c) + EXT_W'(1);
        if (fwd)
        begin
            res = (up >= e) ? '0 : up;
        end
        else
        begin
            res = (c == '0) ? (e - EXT_W'(1)) : (EXT_W'(c) - EXT_W'(1));
        end
        return res[CRD_W-1:0];
    endfunction

endpackage

[rtl/core/periodic_lattice_neighbor_index.sv]
`timescale 1ns / 1ps
// Throughput: one beat per cycle while out_stall is low; the back pipeline holds 11 stages
// (range check, three reciprocal divide steps of two stages, step, three multiply-add stages).
// A four-entry queue decouples input acceptance from the back pipeline.
// Reset (rst_n low, async) empties all stages and sets every extent to 8.
module periodic_lattice_neighbor_index
    import plni_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [EXT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [IDX_W-1:0] site_index,
    input  logic [1:0]       direction,
    input  logic             forward,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] neighbor_index,
    output logic [CRD_W-1:0] coord_x,
    output logic [CRD_W-1:0] coord_y,
    output logic [CRD_W-1:0] coord_z,
    output logic [CRD_W-1:0] coord_t,
    output logic             bad_index
);

    logic [EXT_W-1:0] ext_x_reg;
    logic [EXT_W-1:0] ext_y_reg;
    logic [EXT_W-1:0] ext_z_reg;
    logic [EXT_W-1:0] ext_t_reg;
    ext_t             ext;
    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    item_t            push_item;
    item_t            pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg <= EXT_RESET;
            ext_y_reg <= EXT_RESET;
            ext_z_reg <= EXT_RESET;
            ext_t_reg <= EXT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXTENT_X: ext_x_reg <= cfg_data;
                REG_EXTENT_Y: ext_y_reg <= cfg_data;
                REG_EXTENT_Z: ext_z_reg <= cfg_data;
                REG_EXTENT_T: ext_t_reg <= cfg_data;
                default: ext_x_reg <= ext_x_reg;
            endcase
        end
    end

    assign ext.x = eff_extent(ext_x_reg);
    assign ext.y = eff_extent(ext_y_reg);
    assign ext.z = eff_extent(ext_z_reg);
    assign ext.t = eff_extent(ext_t_reg);

    plni_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ext        (ext),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .site_index (site_index),
        .direction  (direction),
        .forward    (forward),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    plni_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    plni_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ext            (ext),
        .q_not_empty    (q_not_empty),
        .q_item         (pop_item),
        .q_pop          (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .coord_t        (coord_t),
        .bad_index      (bad_index)
    );

endmodule

[rtl/core/plni_front.sv]
`timescale 1ns / 1ps
module plni_front
    import plni_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ext_t             ext,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [IDX_W-1:0] site_index,
    input  logic [1:0]       direction,
    input  logic             forward,
    input  logic             q_full,
    output logic             push,
    output item_t            push_item
);

    logic  fr_valid_reg;
    logic  fr_valid_next;
    item_t fr_item_reg;
    logic  take;

    assign in_stall  = fr_valid_reg && q_full;
    assign take      = in_valid && !in_stall;
    assign push      = fr_valid_reg && !q_full;
    assign push_item = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (take)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    // capture the request and partial volumes for the range check
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_item_reg.site <= site_index;
            fr_item_reg.dir  <= direction;
            fr_item_reg.fwd  <= forward;
            fr_item_reg.p_xy <= PAIR_W'(ext.x) * PAIR_W'(ext.y);
            fr_item_reg.p_zt <= PAIR_W'(ext.z) * PAIR_W'(ext.t);
        end
    end

endmodule

[rtl/core/plni_queue.sv]
`timescale 1ns / 1ps
module plni_queue
    import plni_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    item_t      mem_reg [0:3];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       do_pop;

    assign full      = (cnt_reg == 3'd4);
    assign not_empty = (cnt_reg != 3'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else if (do_pop && !push)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/plni_back.sv]
`timescale 1ns / 1ps
module plni_back
    import plni_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ext_t             ext,
    input  logic             q_not_empty,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] neighbor_index,
    output logic [CRD_W-1:0] coord_x,
    output logic [CRD_W-1:0] coord_y,
    output logic [CRD_W-1:0] coord_z,
    output logic [CRD_W-1:0] coord_t,
    output logic             bad_index
);

    logic [RECIP_W-1:0]  recip_tab [0:MAX_EXTENT];
    stage_t              st_reg  [0:N_STAGES-1];
    stage_t              st_next [0:N_STAGES-1];
    logic [N_STAGES-1:0] vld_reg;
    logic                adv;

    for (genvar g = 0; g <= MAX_EXTENT; g++)
    begin : g_recip
        localparam int D = (g == 0) ? 1 : g;
        localparam logic [RECIP_W-1:0] R = RECIP_W'((64'd1 << IDX_W) / D);
        assign recip_tab[g] = R;
    end

    assign adv   = !vld_reg[N_STAGES-1] || !out_stall;
    assign q_pop = adv;

    always_comb
    begin
        logic [2*PAIR_W-1:0] vol;
        logic [IDX_W-1:0]    diff;
        logic [7:0]          r;
        logic [EXT_W-1:0]    e;
        for (int k = 1; k < N_STAGES; k++)
        begin
            st_next[k] = st_reg[k-1];
        end
        vol             = (2*PAIR_W)'(q_item.p_xy) * (2*PAIR_W)'(q_item.p_zt);
        st_next[0]      = '0;
        st_next[0].bad  = ((2*PAIR_W)'(q_item.site) >= vol);
        st_next[0].dir  = q_item.dir;
        st_next[0].fwd  = q_item.fwd;
        st_next[0].rest = q_item.site;

        // x, y, z split: estimate then one correction
        st_next[1].q = quot_est(st_reg[0].rest, recip_tab[ext.x[CRD_W:0]]);
        st_next[3].q = quot_est(st_reg[2].rest, recip_tab[ext.y[CRD_W:0]]);
        st_next[5].q = quot_est(st_reg[4].rest, recip_tab[ext.z[CRD_W:0]]);

        e    = ext.x;
        diff = st_reg[1].rest - IDX_W'(st_reg[1].q * IDX_W'(e));
        r    = diff[7:0];
        if (r >= 8'(e))
        begin
            st_next[2].cx   = CRD_W'(r - 8'(e));
            st_next[2].rest = st_reg[1].q + IDX_W'(1);
        end
        else
        begin
            st_next[2].cx   = CRD_W'(r);
            st_next[2].rest = st_reg[1].q;
        end

        e    = ext.y;
        diff = st_reg[3].rest - IDX_W'(st_reg[3].q * IDX_W'(e));
        r    = diff[7:0];
        if (r >= 8'(e))
        begin
            st_next[4].cy   = CRD_W'(r - 8'(e));
            st_next[4].rest = st_reg[3].q + IDX_W'(1);
        end
        else
        begin
            st_next[4].cy   = CRD_W'(r);
            st_next[4].rest = st_reg[3].q;
        end

        e    = ext.z;
        diff = st_reg[5].rest - IDX_W'(st_reg[5].q * IDX_W'(e));
        r    = diff[7:0];
        if (r >= 8'(e))
        begin
            st_next[6].cz = CRD_W'(r - 8'(e));
            st_next[6].ct = CRD_W'(st_reg[5].q + IDX_W'(1));
        end
        else
        begin
            st_next[6].cz = CRD_W'(r);
            st_next[6].ct = CRD_W'(st_reg[5].q);
        end

        unique case (st_reg[6].dir)
            DIR_X: st_next[7].cx = step_coord(st_reg[6].cx, ext.x, st_reg[6].fwd);
            DIR_Y: st_next[7].cy = step_coord(st_reg[6].cy, ext.y, st_reg[6].fwd);
            DIR_Z: st_next[7].cz = step_coord(st_reg[6].cz, ext.z, st_reg[6].fwd);
            DIR_T: st_next[7].ct = step_coord(st_reg[6].ct, ext.t, st_reg[6].fwd);
            default: st_next[7].ct = st_reg[6].ct;
        endcase

        st_next[8].acc = IDX_W'(st_reg[7].ct) * IDX_W'(ext.z) + IDX_W'(st_reg[7].cz);
        st_next[9].acc = st_reg[8].acc * IDX_W'(ext.y) + IDX_W'(st_reg[8].cy);
        st_next[10].acc = st_reg[9].acc * IDX_W'(ext.x) + IDX_W'(st_reg[9].cx);
        if (st_reg[9].bad)
        begin
            st_next[10].acc = '0;
            st_next[10].cx  = '0;
            st_next[10].cy  = '0;
            st_next[10].cz  = '0;
            st_next[10].ct  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N_STAGES-2:0], q_not_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid      = vld_reg[N_STAGES-1];
    assign neighbor_index = st_reg[N_STAGES-1].acc;
    assign coord_x        = st_reg[N_STAGES-1].cx;
    assign coord_y        = st_reg[N_STAGES-1].cy;
    assign coord_z        = st_reg[N_STAGES-1].cz;
    assign coord_t        = st_reg[N_STAGES-1].ct;
    assign bad_index      = st_reg[N_STAGES-1].bad;

endmodule

[rtl/core/plni_checker.sv]
`timescale 1ns / 1ps
module plni_checker
    import plni_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_we,
    input logic [2:0]       cfg_index,
    input logic [EXT_W-1:0] cfg_data,
    input logic             in_valid,
    input logic             in_stall,
    input logic [IDX_W-1:0] site_index,
    input logic [1:0]       direction,
    input logic             forward,
    input logic             out_valid,
    input logic             out_stall,
    input logic [IDX_W-1:0] neighbor_index,
    input logic [CRD_W-1:0] coord_x,
    input logic [CRD_W-1:0] coord_y,
    input logic [CRD_W-1:0] coord_z,
    input logic [CRD_W-1:0] coord_t,
    input logic             bad_index
);

    a_bad_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> neighbor_index == '0)
        else $error("flagged beat with nonzero index");

    a_bad_zero_coord: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> coord_x == '0 && coord_y == '0 && coord_z == '0
                                   && coord_t == '0)
        else $error("flagged beat with nonzero coordinates");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(neighbor_index)
                                   && $stable(bad_index))
        else $error("stalled output beat changed");

endmodule

bind periodic_lattice_neighbor_index plni_checker u_plni_checker (.*);
